### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define IMROT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define IMROT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/imrot_pkg.sv
`timescale 1ns / 1ps

package imrot_pkg;

  localparam int MAX_SRC_DIM = 512;
  localparam int MAX_DST_DIM = 1024;
  localparam int FRAC_BITS   = 14;
  localparam int PIXEL_BITS  = 32;

  localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LOAD_IDX_W  = ADDR_W + 1;

  localparam int COEF_W  = 16;
  localparam int SRC_W   = 10;
  localparam int DST_W   = 11;
  localparam int COL_W   = 10;
  localparam int DELTA_W = 12;
  localparam int PROD_W  = DELTA_W + COEF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int QUO_W   = SUM_W - FRAC_BITS;
  localparam int POS_W   = 16;
  localparam int CRD_W   = $clog2(MAX_SRC_DIM);
  localparam int IDX_W   = CRD_W + SRC_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COS_TERM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_TERM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd5;

  localparam logic [0:0] ACT_LOAD = 1'b0;
  localparam logic [0:0] ACT_EMIT = 1'b1;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ADDR,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_en;
    logic emit_en;
    logic mul_en;
    logic sum_en;
    logic addr_en;
    logic read_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_loaded;
  } dp_status_t;

endpackage

### rtl/imrot_if.sv
`timescale 1ns / 1ps

interface imrot_in_if;
  import imrot_pkg::*;
  logic   valid;
  logic   ready;
  logic   action;
  pixel_t pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink (input valid, input action, input pixel_in, output ready);
endinterface

interface imrot_out_if;
  import imrot_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   from_source;
  logic   last;

  modport source (output valid, output pixel_out, output from_source, output last,
                  input ready);
  modport sink (input valid, input pixel_out, input from_source, input last,
                output ready);
endinterface

### rtl/imrot_ctrl.sv
`timescale 1ns / 1ps

module imrot_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_action,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  input  imrot_pkg::dp_status_t  status,
  output imrot_pkg::ctrl_cmd_t   cmd
);
  import imrot_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;
  logic   slot_free;

  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_action == ACT_EMIT && status.frame_loaded) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_OUT;
      ST_OUT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_en = in_valid && in_action == ACT_LOAD;
        cmd.emit_en = in_valid && in_action == ACT_EMIT && status.frame_loaded;
      end
      ST_MUL:  cmd.mul_en  = 1'b1;
      ST_SUM:  cmd.sum_en  = 1'b1;
      ST_ADDR: cmd.addr_en = 1'b1;
      ST_READ: cmd.read_en = 1'b1;
      ST_OUT:  cmd.out_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/imrot_dp.sv
`timescale 1ns / 1ps

module imrot_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [imrot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imrot_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  imrot_pkg::ctrl_cmd_t                cmd,
  output imrot_pkg::dp_status_t               status,
  input  imrot_pkg::pixel_t                   pixel_in,
  output imrot_pkg::pixel_t                   pixel_out,
  output logic                                from_source,
  output logic                                last
);
  import imrot_pkg::*;

  function automatic logic signed [QUO_W-1:0] trunc_q(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] t;
    bias = v[SUM_W-1] ? SUM_W'((1 << FRAC_BITS) - 1) : '0;
    t    = v + bias;
    return t[SUM_W-1:FRAC_BITS];
  endfunction

  logic signed [COEF_W-1:0] cos_r, sin_r;
  logic [SRC_W-1:0]         src_w_r, src_h_r;
  logic [DST_W-1:0]         dst_w_r, dst_h_r;

  logic [LOAD_IDX_W-1:0] load_idx_r, load_idx_nxt;
  logic                  loaded_r, loaded_nxt;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [COL_W-1:0]      row_r, row_nxt;

  logic [SRC_W-1:0] sw, sh;
  logic [DST_W-1:0] dw, dh;

  logic [LOAD_IDX_W-1:0] area;
  logic [LOAD_IDX_W-1:0] base_idx;
  logic [LOAD_IDX_W-1:0] inc_idx;
  logic [ADDR_W-1:0]     wr_addr;

  logic [DST_W-1:0] col_inc, row_inc;
  logic             fin;

  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic signed [PROD_W-1:0]  p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic signed [POS_W-1:0]   sx, sy;
  logic                      inside_now;
  logic [CRD_W-1:0]          sx_r, sy_r;
  logic                      inside_r;
  logic                      last_r;
  logic [IDX_W-1:0]          idx_full;
  logic [ADDR_W-1:0]         rd_addr_r;
  pixel_t                    rd_data_r;
  pixel_t                    pix_out_r;
  logic                      from_src_r;
  logic                      last_out_r;

  pixel_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= COEF_W'(1 << FRAC_BITS);
      sin_r   <= '0;
      src_w_r <= SRC_W'(MAX_SRC_DIM);
      src_h_r <= SRC_W'(MAX_SRC_DIM);
      dst_w_r <= DST_W'(512);
      dst_h_r <= DST_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS_TERM:   cos_r   <= cfg_wdata;
        CFG_SIN_TERM:   sin_r   <= cfg_wdata;
        CFG_SRC_WIDTH:  src_w_r <= cfg_wdata[SRC_W-1:0];
        CFG_SRC_HEIGHT: src_h_r <= cfg_wdata[SRC_W-1:0];
        CFG_DST_WIDTH:  dst_w_r <= cfg_wdata[DST_W-1:0];
        CFG_DST_HEIGHT: dst_h_r <= cfg_wdata[DST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sw = (src_w_r == '0) ? SRC_W'(1) :
         (src_w_r > SRC_W'(MAX_SRC_DIM)) ? SRC_W'(MAX_SRC_DIM) : src_w_r;
    sh = (src_h_r == '0) ? SRC_W'(1) :
         (src_h_r > SRC_W'(MAX_SRC_DIM)) ? SRC_W'(MAX_SRC_DIM) : src_h_r;
    dw = (dst_w_r == '0) ? DST_W'(1) :
         (dst_w_r > DST_W'(MAX_DST_DIM)) ? DST_W'(MAX_DST_DIM) : dst_w_r;
    dh = (dst_h_r == '0) ? DST_W'(1) :
         (dst_h_r > DST_W'(MAX_DST_DIM)) ? DST_W'(MAX_DST_DIM) : dst_h_r;
  end

  always_comb begin
    area     = LOAD_IDX_W'(sw) * LOAD_IDX_W'(sh);
    base_idx = loaded_r ? '0 : load_idx_r;
    wr_addr  = base_idx[ADDR_W-1:0];
    inc_idx  = base_idx + LOAD_IDX_W'(1);
    col_inc  = DST_W'(col_r) + DST_W'(1);
    row_inc  = DST_W'(row_r) + DST_W'(1);
    fin      = (col_inc >= dw) && (row_inc >= dh);

    load_idx_nxt = load_idx_r;
    loaded_nxt   = loaded_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (cmd.load_en) begin
      if (loaded_r) begin
        col_nxt = '0;
        row_nxt = '0;
      end
      if (inc_idx >= area) begin
        loaded_nxt   = 1'b1;
        load_idx_nxt = '0;
      end else begin
        loaded_nxt   = 1'b0;
        load_idx_nxt = inc_idx;
      end
    end else if (cmd.emit_en) begin
      if (col_inc >= dw) begin
        col_nxt = '0;
        row_nxt = (row_inc >= dh) ? '0 : row_inc[COL_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
      loaded_r   <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      load_idx_r <= load_idx_nxt;
      loaded_r   <= loaded_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

  assign status.frame_loaded = loaded_r;

  always_ff @(posedge clk) begin
    if (cmd.load_en) mem[wr_addr] <= pixel_in;
  end

  always_ff @(posedge clk) begin
    if (cmd.read_en) rd_data_r <= mem[rd_addr_r];
  end

  always_comb begin
    sum_x      = SUM_W'(p_xc_r) + SUM_W'(p_ys_r);
    sum_y      = SUM_W'(p_yc_r) - SUM_W'(p_xs_r);
    sx         = POS_W'(trunc_q(sum_x)) + POS_W'(sw[SRC_W-1:1]);
    sy         = POS_W'(trunc_q(sum_y)) + POS_W'(sh[SRC_W-1:1]);
    inside_now = !sx[POS_W-1] && !sy[POS_W-1]
              && (sx[POS_W-2:0] < (POS_W-1)'(sw))
              && (sy[POS_W-2:0] < (POS_W-1)'(sh));
    idx_full   = IDX_W'(sy_r) * IDX_W'(sw) + IDX_W'(sx_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      dx_r   <= DELTA_W'({2'b00, col_r}) - DELTA_W'(dw[DST_W-1:1]);
      dy_r   <= DELTA_W'({2'b00, row_r}) - DELTA_W'(dh[DST_W-1:1]);
      last_r <= fin;
    end
    if (cmd.mul_en) begin
      p_xc_r <= PROD_W'(dx_r) * PROD_W'(cos_r);
      p_ys_r <= PROD_W'(dy_r) * PROD_W'(sin_r);
      p_yc_r <= PROD_W'(dy_r) * PROD_W'(cos_r);
      p_xs_r <= PROD_W'(dx_r) * PROD_W'(sin_r);
    end
    if (cmd.sum_en) begin
      sx_r     <= sx[CRD_W-1:0];
      sy_r     <= sy[CRD_W-1:0];
      inside_r <= inside_now;
    end
    if (cmd.addr_en) rd_addr_r <= idx_full[ADDR_W-1:0];
    if (cmd.out_load) begin
      pix_out_r  <= inside_r ? rd_data_r : '1;
      from_src_r <= inside_r;
      last_out_r <= last_r;
    end
  end

  assign pixel_out   = pix_out_r;
  assign from_source = from_src_r;
  assign last        = last_out_r;

endmodule

### rtl/image_rotation_nearest_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload                          Transfer
// in_chan   sink       action, pixel_in                 valid && ready
// out_chan  source     pixel_out, from_source, last     valid && ready
// cfg       write      cfg_index, cfg_wdata             cfg_we
//
// A load is taken in the idle state; loads run back to back from the frame store write port.
// An emit runs through the steps accept, multiply, sum and range check, address
// multiply, frame store read, output register load; the sequencer holds one at a time.
// Synchronous active-low reset clears control and configuration; frame store is not cleared.
// A pending result waits in the output register while the next item is taken in;
// a second emit stalls in its last step until that result transfers.
module image_rotation_nearest_core (
  input  logic                             clk,
  input  logic                             rst_n,
  imrot_in_if.sink                         in_chan,
  imrot_out_if.source                      out_chan,
  input  logic                             cfg_we,
  input  logic [imrot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imrot_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import imrot_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  imrot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .status    (status),
    .cmd       (cmd)
  );

  imrot_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .status      (status),
    .pixel_in    (in_chan.pixel_in),
    .pixel_out   (out_chan.pixel_out),
    .from_source (out_chan.from_source),
    .last        (out_chan.last)
  );

endmodule

### rtl/imrot_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imrot_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_action,
  input logic                out_valid,
  input logic                out_ready,
  input imrot_pkg::pixel_t   pixel_out,
  input logic                from_source
);
  import imrot_pkg::*;

  `IMROT_ASSERT_ALWAYS(a_no_out_after_reset, clk, !rst_n |=> !out_valid, "output valid after reset")
  `IMROT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(pixel_out), "stalled output changed")
  `IMROT_ASSERT(a_fill_white, clk, rst_n, out_valid && !from_source |-> pixel_out == '1, "fill pixel not white")
  `IMROT_ASSERT(a_load_no_result, clk, rst_n, in_valid && in_ready && in_action == ACT_LOAD |=> !$rose(out_valid), "result right after load")

endmodule

bind image_rotation_nearest_core imrot_chk u_imrot_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_action   (in_chan.action),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .pixel_out   (out_chan.pixel_out),
  .from_source (out_chan.from_source)
);

### tb/image_rotation_nearest_core_tb.sv
`timescale 1ns / 1ps

module image_rotation_nearest_core_tb;
  import imrot_pkg::*;

  localparam int     CLK_HALF      = 6;
  localparam int     RESET_CYCLES  = 6;
  localparam int     SETTLE_CYCLES = 12;
  localparam int     HOLD_CYCLES   = 300;
  localparam longint CYCLE_LIMIT   = 800000;
  localparam longint Q_ONE         = longint'(1) << FRAC_BITS;

  typedef struct packed {
    pixel_t pixel;
    logic   from_source;
    logic   last;
  } out_pixel_t;

  class rotated_pixel_checker;
    pixel_t            frame_mem[];
    bit                written[];
    int unsigned       load_idx;
    int unsigned       col;
    int unsigned       row;
    bit                loaded;
    logic [COEF_W-1:0] cos_reg;
    logic [COEF_W-1:0] sin_reg;
    logic [SRC_W-1:0]  src_w_reg;
    logic [SRC_W-1:0]  src_h_reg;
    logic [DST_W-1:0]  dst_w_reg;
    logic [DST_W-1:0]  dst_h_reg;
    out_pixel_t        pending_pixels[$];
    int                mismatches;
    int                loads;
    int                results;
    int                fills;
    int                frame_ends;
    int                ignored;
    int                useful;

    function new();
      frame_mem = new[STORE_DEPTH];
      written   = new[STORE_DEPTH];
      load_idx  = 0;
      col       = 0;
      row       = 0;
      loaded    = 0;
      cos_reg   = 16'd16384;
      sin_reg   = '0;
      src_w_reg = 10'd512;
      src_h_reg = 10'd512;
      dst_w_reg = 11'd512;
      dst_h_reg = 11'd512;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned src_w();
      return fit(src_w_reg, MAX_SRC_DIM);
    endfunction

    function int unsigned src_h();
      return fit(src_h_reg, MAX_SRC_DIM);
    endfunction

    function int unsigned dst_w();
      return fit(dst_w_reg, MAX_DST_DIM);
    endfunction

    function int unsigned dst_h();
      return fit(dst_h_reg, MAX_DST_DIM);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_COS_TERM:   cos_reg   = val[COEF_W-1:0];
        CFG_SIN_TERM:   sin_reg   = val[COEF_W-1:0];
        CFG_SRC_WIDTH:  src_w_reg = val[SRC_W-1:0];
        CFG_SRC_HEIGHT: src_h_reg = val[SRC_W-1:0];
        CFG_DST_WIDTH:  dst_w_reg = val[DST_W-1:0];
        CFG_DST_HEIGHT: dst_h_reg = val[DST_W-1:0];
        default: ;
      endcase
    endfunction

    // Map the current output position back into the source frame.
    function bit map_to_source(output int unsigned addr);
      longint      c;
      longint      s;
      longint      dx;
      longint      dy;
      longint      sx;
      longint      sy;
      int unsigned sw;
      int unsigned sh;
      sw   = src_w();
      sh   = src_h();
      c    = longint'($signed(cos_reg));
      s    = longint'($signed(sin_reg));
      dx   = longint'(col) - longint'(dst_w() / 2);
      dy   = longint'(row) - longint'(dst_h() / 2);
      sy   = (dy * c - dx * s) / Q_ONE + longint'(sh / 2);
      sx   = (dx * c + dy * s) / Q_ONE + longint'(sw / 2);
      addr = 0;
      if (sy < 0 || sy >= longint'(sh) || sx < 0 || sx >= longint'(sw)) return 0;
      addr = 32'(sy * longint'(sw) + sx);
      return 1;
    endfunction

    function bit emit_unsafe();
      int unsigned addr;
      if (!loaded) return 0;
      if (!map_to_source(addr)) return 0;
      return !written[addr];
    endfunction

    function void note_input(logic act, pixel_t pix);
      int unsigned addr;
      out_pixel_t  want;
      bit          hit;
      if (act == ACT_LOAD) begin
        if (loaded) begin
          loaded   = 0;
          load_idx = 0;
          col      = 0;
          row      = 0;
        end
        if (load_idx < STORE_DEPTH) begin
          frame_mem[load_idx] = pix;
          written[load_idx]   = 1;
        end
        load_idx++;
        if (load_idx >= src_w() * src_h()) begin
          loaded   = 1;
          load_idx = 0;
        end
        loads++;
        useful++;
      end else if (!loaded) begin
        ignored++;
      end else begin
        hit              = map_to_source(addr);
        want.pixel       = hit ? frame_mem[addr] : '1;
        want.from_source = hit;
        want.last        = (col + 1 >= dst_w()) && (row + 1 >= dst_h());
        pending_pixels.push_back(want);
        useful++;
        col++;
        if (col >= dst_w()) begin
          col = 0;
          row++;
          if (row >= dst_h()) row = 0;
        end
      end
    endfunction

    function void check_result(pixel_t pix, logic from_src, logic fin);
      out_pixel_t want;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output transfer pixel_out=%h from_source=%b last=%b",
                   pix, from_src, fin);
        return;
      end
      want = pending_pixels.pop_front();
      results++;
      if (!want.from_source) fills++;
      if (want.last) frame_ends++;
      if (pix !== want.pixel || from_src !== want.from_source || fin !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output %0d expected %h/%b/%b, got %h/%b/%b (pixel/from_source/last)",
                   results, want.pixel, want.from_source, want.last, pix, from_src, fin);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    steady       = 0;
  bit                    hold_request = 0;
  int                    settings_used = 0;
  longint                cycle_count;
  rotated_pixel_checker  rot_sb = new();

  imrot_in_if  in_if ();
  imrot_out_if out_if ();

  image_rotation_nearest_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : receiver
    int stall;
    int hold;
    stall = 0;
    hold  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready)
        rot_sb.check_result(out_if.pixel_out, out_if.from_source, out_if.last);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (hold_request) begin
        // hold off long enough to back up the input side
        hold_request = 0;
        hold = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 9);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic act, pixel_t pix);
    // never read a store entry that was not written since reset
    if (act == ACT_EMIT && rot_sb.emit_unsafe()) act = ACT_LOAD;
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.pixel_in <= pix;
    do @(posedge clk); while (!in_if.ready);
    rot_sb.note_input(act, pix);
  endtask

  task automatic emit_run(int n);
    repeat (n) send_item(ACT_EMIT, $urandom);
  endtask

  task automatic load_frame();
    int n;
    n = rot_sb.src_w() * rot_sb.src_h();
    repeat (n) send_item(ACT_LOAD, $urandom);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (rot_sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    rot_sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] c, logic [CFG_DATA_W-1:0] s,
                           logic [CFG_DATA_W-1:0] sw, logic [CFG_DATA_W-1:0] sh,
                           logic [CFG_DATA_W-1:0] dw, logic [CFG_DATA_W-1:0] dh);
    settle();
    write_reg(CFG_COS_TERM, c);
    write_reg(CFG_SIN_TERM, s);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size(int hi, logic [CFG_DATA_W-1:0] rare);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return rare;
    return CFG_DATA_W'($urandom_range(1, hi));
  endfunction

  task automatic random_phase(int budget, bit pressure);
    int start;
    int c;
    int s;
    int n;
    case ($urandom_range(0, 5))
      0: begin c = 16384;  s = 0;      end
      1: begin c = 0;      s = 16384;  end
      2: begin c = -16384; s = 0;      end
      3: begin c = 0;      s = -16384; end
      default: begin
        c = int'($urandom_range(0, 32768)) - 16384;
        s = int'($urandom_range(0, 32768)) - 16384;
      end
    endcase
    configure(CFG_DATA_W'(c), CFG_DATA_W'(s), pick_size(8, 16'd16), pick_size(8, 16'd16),
              pick_size(12, 16'hFFFF), pick_size(12, 16'hFFFF));
    if (pressure) begin
      while (!rot_sb.loaded) send_item(ACT_LOAD, $urandom);
      hold_request = 1;
      emit_run(24);
    end
    start = rot_sb.useful;
    while (rot_sb.useful - start < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        load_frame();
        n = rot_sb.dst_w() * rot_sb.dst_h() + 2;
        if (n > 40) n = 40;
        emit_run($urandom_range(1, n));
      end else begin
        send_item(1'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  initial begin : stimulus
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    in_if.valid    <= 1'b0;
    in_if.action   <= ACT_LOAD;
    in_if.pixel_in <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // emit before any frame, then a tiny frame with an emit mid-load
    send_item(ACT_EMIT, 32'h1234_5678);
    configure(16384, 0, 2, 2, 3, 2);
    send_item(ACT_LOAD, 32'h0000_0000);
    send_item(ACT_LOAD, 32'hFFFF_FFFF);
    send_item(ACT_EMIT, 32'hFFFF_FFFF);
    send_item(ACT_LOAD, 32'hA5A5_5A5A);
    send_item(ACT_LOAD, 32'h5A5A_A5A5);
    emit_run(7);
    send_item(ACT_LOAD, 32'h8000_0001);

    // shrink source mid-load, then shrink output mid-frame
    configure(11585, 11585, 3, 3, 4, 4);
    repeat (3) send_item(ACT_LOAD, $urandom);
    configure(11585, 11585, 2, 2, 4, 4);
    send_item(ACT_LOAD, $urandom);
    emit_run(7);
    configure(11585, 11585, 2, 2, 3, 2);
    emit_run(2);

    // size extremes, saturation, and upper data bits ignored
    configure(64, 0, 4, 1, 16'h07FF, 1);
    load_frame();
    emit_run(6);
    configure(0, 16384, 0, 0, 0, 0);
    load_frame();
    emit_run(3);
    send_item(ACT_LOAD, $urandom);
    emit_run(1);
    configure(16384, 16'hC000, 16'hFC03, 16'hFC02, 16'hF805, 16'hF803);
    load_frame();
    emit_run(16);

    for (int p = 0; p < 7; p++) begin
      if (p == 6) steady = 1;
      random_phase(40, p == 2);
    end

    settle();
    $display("Covered %0d pixel loads and %0d output pixels (%0d fill, %0d frame ends)",
             rot_sb.loads, rot_sb.results, rot_sb.fills, rot_sb.frame_ends);
    $display("across %0d register settings; %0d emits dropped before a full frame",
             settings_used, rot_sb.ignored);
    if (rot_sb.mismatches == 0 && rot_sb.pending_pixels.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/imrot_pkg.sv
rtl/imrot_if.sv
rtl/imrot_ctrl.sv
rtl/imrot_dp.sv
rtl/image_rotation_nearest_core.sv
rtl/imrot_chk.sv
tb/image_rotation_nearest_core_tb.sv
